@@ rtl/oqmm_pkg.sv @@
// package for the octo-quad motor mixer
// holds the item and configuration types and the fixed constants, no dependencies
package oqmm_pkg;

	localparam int PULSE_W   = 12;
	localparam int DRIVE_W   = 12;
	localparam int RATIO_W   = 9;
	localparam int OFFSET_W  = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;
	localparam int SCALE_W   = 16;
	localparam int NUM_MOTOR = 8;

	localparam logic [SCALE_W-1:0] SCALE_X_Q16 = 16'd46334;
	localparam logic [PULSE_W-1:0] PULSE_MAX   = 12'd4095;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_IS_X    = 3'd0,
		REG_TOP_RATIO_Q8  = 3'd1,
		REG_PULSE_FLOOR   = 3'd2,
		REG_PULSE_CEILING = 3'd3,
		REG_SPIN_OFFSET   = 3'd4,
		REG_CUT_WHEN_IDLE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                frame_is_x;
		logic [RATIO_W-1:0]  top_ratio_q8;
		logic [PULSE_W-1:0]  pulse_floor;
		logic [PULSE_W-1:0]  pulse_ceiling;
		logic [OFFSET_W-1:0] spin_offset;
		logic                cut_when_idle;
	} cfg_t;

	typedef struct packed {
		logic                      armed;
		logic signed [DRIVE_W-1:0] roll_drive;
		logic signed [DRIVE_W-1:0] pitch_drive;
		logic signed [DRIVE_W-1:0] yaw_drive;
		logic [PULSE_W-1:0]        throttle_pulse;
		logic signed [DRIVE_W-1:0] throttle_cmd;
		logic signed [DRIVE_W-1:0] throttle_stick;
	} in_item_t;

	typedef struct packed {
		logic [NUM_MOTOR-1:0][PULSE_W-1:0] motor;
		logic                              arm_request;
	} out_item_t;

endpackage

@@ rtl/oqmm_if.sv @@
// channel interfaces for the octo-quad motor mixer: input items, results, register writes
// widths come from oqmm_pkg
interface oqmm_in_if;
	logic                                valid;
	logic                                ready;
	logic                                armed;
	logic signed [oqmm_pkg::DRIVE_W-1:0] roll_drive;
	logic signed [oqmm_pkg::DRIVE_W-1:0] pitch_drive;
	logic signed [oqmm_pkg::DRIVE_W-1:0] yaw_drive;
	logic [oqmm_pkg::PULSE_W-1:0]        throttle_pulse;
	logic signed [oqmm_pkg::DRIVE_W-1:0] throttle_cmd;
	logic signed [oqmm_pkg::DRIVE_W-1:0] throttle_stick;

	modport source (
		output valid, armed, roll_drive, pitch_drive, yaw_drive,
		       throttle_pulse, throttle_cmd, throttle_stick,
		input  ready
	);
	modport sink (
		input  valid, armed, roll_drive, pitch_drive, yaw_drive,
		       throttle_pulse, throttle_cmd, throttle_stick,
		output ready
	);
endinterface

interface oqmm_out_if;
	logic                         valid;
	logic                         ready;
	logic [oqmm_pkg::PULSE_W-1:0] chan1_top_ccw;
	logic [oqmm_pkg::PULSE_W-1:0] chan2_bottom_cw;
	logic [oqmm_pkg::PULSE_W-1:0] chan3_top_ccw;
	logic [oqmm_pkg::PULSE_W-1:0] chan4_bottom_cw;
	logic [oqmm_pkg::PULSE_W-1:0] chan7_top_ccw;
	logic [oqmm_pkg::PULSE_W-1:0] chan8_bottom_cw;
	logic [oqmm_pkg::PULSE_W-1:0] chan10_top_ccw;
	logic [oqmm_pkg::PULSE_W-1:0] chan11_bottom_cw;
	logic                         arm_request;

	modport source (
		output valid, chan1_top_ccw, chan2_bottom_cw, chan3_top_ccw, chan4_bottom_cw,
		       chan7_top_ccw, chan8_bottom_cw, chan10_top_ccw, chan11_bottom_cw,
		       arm_request,
		input  ready
	);
	modport sink (
		input  valid, chan1_top_ccw, chan2_bottom_cw, chan3_top_ccw, chan4_bottom_cw,
		       chan7_top_ccw, chan8_bottom_cw, chan10_top_ccw, chan11_bottom_cw,
		       arm_request,
		output ready
	);
endinterface

interface oqmm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [oqmm_pkg::CFG_IDX_W-1:0] index;
	logic [oqmm_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/oqmm_datapath.sv @@
// three-stage mixing pipeline: multiplies, mix sums, clamp and output register
// uses oqmm_pkg types; configuration comes from the register block in the top level
module oqmm_datapath #(
	parameter int RATIO_FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  oqmm_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  oqmm_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output oqmm_pkg::out_item_t out_item
);
	import oqmm_pkg::*;

	localparam int PROD_W = PULSE_W + RATIO_W;
	localparam int TOP_W  = PROD_W - RATIO_FRAC_BITS;
	localparam int MAG_W  = DRIVE_W;
	localparam int SPROD_W = MAG_W + SCALE_W;
	localparam int SUM_W  = ((TOP_W > 13) ? TOP_W : 13) + 2;
	localparam int LO_W   = PULSE_W + 1;

	// handshake
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// stage 1: products
	logic [MAG_W-1:0]           roll_mag, pitch_mag;
	logic                       idle_s1, arm_req_s1, cmd_pos_s1;
	logic [PULSE_W-1:0]         thr_s1;
	logic signed [DRIVE_W-1:0]  yaw_s1, roll_s1, pitch_s1;
	logic [PROD_W-1:0]          top_prod_s1;
	logic [SPROD_W-1:0]         roll_prod_s1, pitch_prod_s1;
	logic                       roll_neg_s1, pitch_neg_s1;

	assign roll_mag  = in_item.roll_drive[DRIVE_W-1] ?
		MAG_W'(-in_item.roll_drive) : MAG_W'(in_item.roll_drive);
	assign pitch_mag = in_item.pitch_drive[DRIVE_W-1] ?
		MAG_W'(-in_item.pitch_drive) : MAG_W'(in_item.pitch_drive);

	always_ff @(posedge clk) begin
		if (adv1) begin
			idle_s1       <= !in_item.armed ||
				(cfg.cut_when_idle && (in_item.throttle_cmd <= 0));
			arm_req_s1    <= !in_item.armed && (in_item.throttle_stick > 0);
			cmd_pos_s1    <= in_item.throttle_cmd > 0;
			thr_s1        <= in_item.throttle_pulse;
			yaw_s1        <= in_item.yaw_drive;
			roll_s1       <= in_item.roll_drive;
			pitch_s1      <= in_item.pitch_drive;
			top_prod_s1   <= PROD_W'(in_item.throttle_pulse) * PROD_W'(cfg.top_ratio_q8);
			roll_prod_s1  <= SPROD_W'(roll_mag) * SPROD_W'(SCALE_X_Q16);
			pitch_prod_s1 <= SPROD_W'(pitch_mag) * SPROD_W'(SCALE_X_Q16);
			roll_neg_s1   <= in_item.roll_drive[DRIVE_W-1];
			pitch_neg_s1  <= in_item.pitch_drive[DRIVE_W-1];
		end
	end

	// stage 2: mix sums
	logic [TOP_W-1:0]                  top_val;
	logic [MAG_W-1:0]                  roll_sc, pitch_sc;
	logic signed [SUM_W-1:0]           top_e, thr_e, yaw_e, ra, pa;
	logic signed [SUM_W-1:0]           mix [NUM_MOTOR];
	logic signed [SUM_W-1:0]           mix_s2 [NUM_MOTOR];
	logic                              idle_s2, arm_req_s2;
	logic [LO_W-1:0]                   lo_s2;

	assign top_val  = TOP_W'(top_prod_s1 >> RATIO_FRAC_BITS);
	assign roll_sc  = roll_prod_s1[SPROD_W-1:SCALE_W];
	assign pitch_sc = pitch_prod_s1[SPROD_W-1:SCALE_W];
	assign top_e    = $signed(SUM_W'(top_val));
	assign thr_e    = $signed(SUM_W'(thr_s1));
	assign yaw_e    = SUM_W'(yaw_s1);

	always_comb begin
		if (cfg.frame_is_x) begin
			ra = roll_neg_s1  ? -$signed(SUM_W'(roll_sc))  : $signed(SUM_W'(roll_sc));
			pa = pitch_neg_s1 ? -$signed(SUM_W'(pitch_sc)) : $signed(SUM_W'(pitch_sc));
			mix[0] = top_e - ra - pa + yaw_e;
			mix[1] = thr_e - ra - pa - yaw_e;
			mix[2] = top_e + ra - pa + yaw_e;
			mix[3] = thr_e + ra - pa - yaw_e;
			mix[4] = top_e + ra + pa + yaw_e;
			mix[5] = thr_e + ra + pa - yaw_e;
			mix[6] = top_e - ra + pa + yaw_e;
			mix[7] = thr_e - ra + pa - yaw_e;
		end else begin
			ra = SUM_W'(roll_s1);
			pa = SUM_W'(pitch_s1);
			mix[0] = top_e + ra + yaw_e;
			mix[1] = thr_e + ra - yaw_e;
			mix[2] = top_e - pa + yaw_e;
			mix[3] = thr_e - pa - yaw_e;
			mix[4] = top_e - ra + yaw_e;
			mix[5] = thr_e - ra - yaw_e;
			mix[6] = top_e + pa + yaw_e;
			mix[7] = thr_e + pa - yaw_e;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mix_s2     <= mix;
			idle_s2    <= idle_s1;
			arm_req_s2 <= arm_req_s1;
			lo_s2      <= LO_W'(cfg.pulse_floor) +
				(cmd_pos_s1 ? LO_W'(cfg.spin_offset) : LO_W'(0));
		end
	end

	// stage 3: clamp into the output register
	function automatic logic [PULSE_W-1:0] clamp_motor(
		input logic signed [SUM_W-1:0] v,
		input logic [LO_W-1:0]         lo,
		input logic [PULSE_W-1:0]      hi
	);
		logic signed [SUM_W-1:0] t;
		t = v;
		if (t > $signed(SUM_W'(hi))) t = $signed(SUM_W'(hi));
		if (t < $signed(SUM_W'(lo))) t = $signed(SUM_W'(lo));
		if (t < 0) t = '0;
		if (t > $signed(SUM_W'(PULSE_MAX))) t = $signed(SUM_W'(PULSE_MAX));
		return PULSE_W'(t);
	endfunction

	logic [NUM_MOTOR-1:0][PULSE_W-1:0] motor_nx;

	always_comb begin
		for (int k = 0; k < NUM_MOTOR; k++) begin
			motor_nx[k] = idle_s2 ? cfg.pulse_floor :
				clamp_motor(mix_s2[k], lo_s2, cfg.pulse_ceiling);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_item.motor       <= motor_nx;
			out_item.arm_request <= arm_req_s2;
		end
	end

endmodule

@@ rtl/octa_quad_motor_mixer.sv @@
// top level of the coaxial octo-quad motor mixer: register block and channel wiring
// depends on oqmm_pkg, oqmm_if and oqmm_datapath
//
//  channel     dir   transaction
//  upstream    in    one input item (armed, drives, throttle fields)
//  downstream  out   one result item (eight motor pulses, arm_request)
//  cfg         in    one register write (index, data), always ready
//
// three register stages (multiply / mix / clamp); the result is valid once the input item
// has passed all three; one item per cycle sustained while downstream does not stall
// arst_n clears the stage valid bits and loads the register reset values
// a downstream stall holds only full stages; upstream ready falls only when all are full
module octa_quad_motor_mixer #(
	parameter int RATIO_FRAC_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	oqmm_in_if.sink    upstream,
	oqmm_out_if.source downstream,
	oqmm_cfg_if.sink   cfg
);
	import oqmm_pkg::*;

	cfg_t      cfg_q;
	in_item_t  in_item;
	out_item_t out_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_is_x    <= 1'b1;
			cfg_q.top_ratio_q8  <= 9'd256;
			cfg_q.pulse_floor   <= 12'd1100;
			cfg_q.pulse_ceiling <= 12'd1900;
			cfg_q.spin_offset   <= 10'd130;
			cfg_q.cut_when_idle <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_IS_X:    cfg_q.frame_is_x    <= cfg.data[0];
				REG_TOP_RATIO_Q8:  cfg_q.top_ratio_q8  <= cfg.data[RATIO_W-1:0];
				REG_PULSE_FLOOR:   cfg_q.pulse_floor   <= cfg.data[PULSE_W-1:0];
				REG_PULSE_CEILING: cfg_q.pulse_ceiling <= cfg.data[PULSE_W-1:0];
				REG_SPIN_OFFSET:   cfg_q.spin_offset   <= cfg.data[OFFSET_W-1:0];
				REG_CUT_WHEN_IDLE: cfg_q.cut_when_idle <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign in_item.armed          = upstream.armed;
	assign in_item.roll_drive     = upstream.roll_drive;
	assign in_item.pitch_drive    = upstream.pitch_drive;
	assign in_item.yaw_drive      = upstream.yaw_drive;
	assign in_item.throttle_pulse = upstream.throttle_pulse;
	assign in_item.throttle_cmd   = upstream.throttle_cmd;
	assign in_item.throttle_stick = upstream.throttle_stick;

	oqmm_datapath #(
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (upstream.valid),
		.in_ready (upstream.ready),
		.in_item  (in_item),
		.out_valid(downstream.valid),
		.out_ready(downstream.ready),
		.out_item (out_item)
	);

	assign downstream.chan1_top_ccw    = out_item.motor[0];
	assign downstream.chan2_bottom_cw  = out_item.motor[1];
	assign downstream.chan3_top_ccw    = out_item.motor[2];
	assign downstream.chan4_bottom_cw  = out_item.motor[3];
	assign downstream.chan7_top_ccw    = out_item.motor[4];
	assign downstream.chan8_bottom_cw  = out_item.motor[5];
	assign downstream.chan10_top_ccw   = out_item.motor[6];
	assign downstream.chan11_bottom_cw = out_item.motor[7];
	assign downstream.arm_request      = out_item.arm_request;

endmodule
